FILE: sv/image_gradient_xy_unit_defines.svh
// assertion macros for the image gradient unit
`ifndef IMAGE_GRADIENT_XY_UNIT_DEFINES_SVH
`define IMAGE_GRADIENT_XY_UNIT_DEFINES_SVH

// same-cycle implication, quiet while reset is low
`define IGXY_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, quiet while reset is low
`define IGXY_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

// next-cycle implication that also holds through reset
`define IGXY_ASSERT_ALWAYS(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: sv/igxy_pkg.sv
`timescale 1ns / 1ps

package igxy_pkg;

    localparam int PIX_W          = 8;
    localparam int GRAD_W         = 10;
    localparam int COORD_W        = 10;
    localparam int CFG_W          = 11;
    localparam int IN_DATA_W      = 8;
    localparam int OUT_DATA_W     = 2 * GRAD_W + 2 * COORD_W;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int CFG_WIDTH_RST  = 640;
    localparam int CFG_HEIGHT_RST = 480;
    localparam int QUEUE_DEPTH    = 4;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic first_col;
        logic second_col;
        logic last_col;
        logic row_one;
        logic last_row;
        logic above;
    } t_item_flags;

    // one classified pixel with the line store reads that belong to it
    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [PIX_W-1:0]   p_c;
        logic [PIX_W-1:0]   p_cn;
        logic [PIX_W-1:0]   o_c;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        t_item_flags        flags;
    } t_item;

    typedef struct packed {
        logic [COORD_W-1:0]       col;
        logic [COORD_W-1:0]       row;
        logic signed [GRAD_W-1:0] grad_y;
        logic signed [GRAD_W-1:0] grad_x;
    } t_result;

    function automatic logic signed [GRAD_W-1:0] grad_diff(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b
    );
        logic signed [GRAD_W-1:0] sa;
        logic signed [GRAD_W-1:0] sb;
        sa = $signed({{(GRAD_W - PIX_W){1'b0}}, a});
        sb = $signed({{(GRAD_W - PIX_W){1'b0}}, b});
        return sa - sb;
    endfunction

    function automatic logic signed [GRAD_W-1:0] grad_double(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b
    );
        return grad_diff(a, b) <<< 1;
    endfunction

endpackage

FILE: sv/igxy_line_ram.sv
`timescale 1ns / 1ps

module igxy_line_ram #(
    parameter int WIDTH = igxy_pkg::PIX_W,
    parameter int DEPTH = igxy_pkg::MAX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // read-first: a read of the address being written returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_a <= r_mem[i_raddr_a];
            r_rd_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

FILE: sv/igxy_front.sv
`timescale 1ns / 1ps

module igxy_front #(
    parameter int MAX_WIDTH  = igxy_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = igxy_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_last_col,
    input  logic [$clog2(MAX_HEIGHT)-1:0] i_last_row,
    input  logic                          i_restart,
    input  logic                          i_s_tvalid,
    input  logic [igxy_pkg::PIX_W-1:0]    i_s_tdata,
    output logic                          o_s_tready,
    input  logic                          i_full,
    output logic                          o_push,
    output igxy_pkg::t_item               o_item
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic [RW-1:0] r_row;
    logic [RW-1:0] n_row;
    logic          r_bank;
    logic          n_bank;

    logic            r_s1_valid;
    logic            r_s1_bank;
    igxy_pkg::t_item r_s1;
    igxy_pkg::t_item w_s1_next;

    logic          w_accept;
    logic          w_push;
    logic [CW-1:0] w_raddr_b;

    logic [igxy_pkg::PIX_W-1:0] w_ram0_a;
    logic [igxy_pkg::PIX_W-1:0] w_ram0_b;
    logic [igxy_pkg::PIX_W-1:0] w_ram1_a;
    logic [igxy_pkg::PIX_W-1:0] w_ram1_b;

    // the stage register only moves on when the queue takes it, so the ram
    // read data stays put until the next pixel is taken
    assign w_push     = r_s1_valid && !i_full;
    assign o_s_tready = i_rst_n && (!r_s1_valid || !i_full);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_raddr_b  = (r_col == i_last_col) ? r_col : r_col + CW'(1);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_bank = r_bank;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (w_accept) begin
            if (r_col == i_last_col) begin
                n_col  = '0;
                n_bank = !r_bank;
                n_row  = (r_row == i_last_row) ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_comb begin
        w_s1_next                  = '0;
        w_s1_next.pix              = i_s_tdata;
        w_s1_next.row              = igxy_pkg::COORD_W'(r_row);
        w_s1_next.col              = igxy_pkg::COORD_W'(r_col);
        w_s1_next.flags.first_col  = (r_col == '0);
        w_s1_next.flags.second_col = (r_col == CW'(1));
        w_s1_next.flags.last_col   = (r_col == i_last_col);
        w_s1_next.flags.row_one    = (r_row == RW'(1));
        w_s1_next.flags.last_row   = (r_row == i_last_row);
        w_s1_next.flags.above      = (r_row != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_bank     <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_bank <= n_bank;
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1      <= w_s1_next;
            r_s1_bank <= r_bank;
        end
    end

    // bank r_bank takes the incoming row over the row two above it
    igxy_line_ram #(
        .WIDTH (igxy_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram0 (
        .i_clk     (i_clk),
        .i_we      (w_accept && !r_bank),
        .i_waddr   (r_col),
        .i_wdata   (i_s_tdata),
        .i_re      (w_accept),
        .i_raddr_a (r_col),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_ram0_a),
        .o_rdata_b (w_ram0_b)
    );

    igxy_line_ram #(
        .WIDTH (igxy_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram1 (
        .i_clk     (i_clk),
        .i_we      (w_accept && r_bank),
        .i_waddr   (r_col),
        .i_wdata   (i_s_tdata),
        .i_re      (w_accept),
        .i_raddr_a (r_col),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_ram1_a),
        .o_rdata_b (w_ram1_b)
    );

    always_comb begin
        o_item      = r_s1;
        o_item.o_c  = r_s1_bank ? w_ram1_a : w_ram0_a;
        o_item.p_c  = r_s1_bank ? w_ram0_a : w_ram1_a;
        o_item.p_cn = r_s1_bank ? w_ram0_b : w_ram1_b;
    end

    assign o_push = w_push;

endmodule

FILE: sv/igxy_queue.sv
`timescale 1ns / 1ps

module igxy_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  igxy_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    output igxy_pkg::t_item o_item,
    input  logic            i_pop
);

    localparam int PTR_W = $clog2(igxy_pkg::QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    igxy_pkg::t_item r_mem [igxy_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_W'(igxy_pkg::QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_item    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: sv/igxy_back.sv
`timescale 1ns / 1ps

module igxy_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  igxy_pkg::t_item                 i_item,
    output logic                            o_pop,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [igxy_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast
);

    logic       r_hold;
    logic [1:0] r_idx;
    logic [1:0] r_last_idx;
    logic [1:0] w_last_idx;
    logic       w_out_acc;
    logic       w_at_last;
    logic       w_pop;

    igxy_pkg::t_result r_res0;
    igxy_pkg::t_result r_res1;
    igxy_pkg::t_result r_res2;
    igxy_pkg::t_result w_res0;
    igxy_pkg::t_result w_res1;
    igxy_pkg::t_result w_res2;
    igxy_pkg::t_result w_sel;

    // neighbours left behind by earlier pixels of the same row
    logic [igxy_pkg::PIX_W-1:0] r_p_left;
    logic [igxy_pkg::PIX_W-1:0] r_x1;
    logic [igxy_pkg::PIX_W-1:0] r_x2;

    assign w_out_acc = r_hold && i_m_tready;
    assign w_at_last = (r_idx == r_last_idx);
    assign w_pop     = i_valid && (!r_hold || (w_out_acc && w_at_last));

    always_comb begin
        if (!i_item.flags.last_row || i_item.flags.first_col) begin
            w_last_idx = 2'd0;
        end else if (i_item.flags.last_col) begin
            w_last_idx = 2'd2;
        end else begin
            w_last_idx = 2'd1;
        end
    end

    always_comb begin
        // pixel above the incoming one
        if (i_item.flags.first_col) begin
            w_res0.grad_x = igxy_pkg::grad_double(i_item.p_cn, i_item.p_c);
        end else if (i_item.flags.last_col) begin
            w_res0.grad_x = igxy_pkg::grad_double(i_item.p_c, r_p_left);
        end else begin
            w_res0.grad_x = igxy_pkg::grad_diff(i_item.p_cn, r_p_left);
        end
        if (i_item.flags.row_one) begin
            w_res0.grad_y = igxy_pkg::grad_double(i_item.pix, i_item.p_c);
        end else begin
            w_res0.grad_y = igxy_pkg::grad_diff(i_item.pix, i_item.o_c);
        end
        w_res0.row = i_item.row - igxy_pkg::COORD_W'(1);
        w_res0.col = i_item.col;

        // bottom row, pixel to the left
        if (i_item.flags.second_col) begin
            w_res1.grad_x = igxy_pkg::grad_double(i_item.pix, r_x1);
        end else begin
            w_res1.grad_x = igxy_pkg::grad_diff(i_item.pix, r_x2);
        end
        w_res1.grad_y = igxy_pkg::grad_double(r_x1, r_p_left);
        w_res1.row    = i_item.row;
        w_res1.col    = i_item.col - igxy_pkg::COORD_W'(1);

        // bottom right corner
        w_res2.grad_x = igxy_pkg::grad_double(i_item.pix, r_x1);
        w_res2.grad_y = igxy_pkg::grad_double(i_item.pix, i_item.p_c);
        w_res2.row    = i_item.row;
        w_res2.col    = i_item.col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold     <= 1'b0;
            r_idx      <= '0;
            r_last_idx <= '0;
        end else begin
            if (w_pop) begin
                r_hold     <= i_item.flags.above;
                r_idx      <= '0;
                r_last_idx <= w_last_idx;
            end else if (w_out_acc) begin
                if (w_at_last) begin
                    r_hold <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_res0   <= w_res0;
            r_res1   <= w_res1;
            r_res2   <= w_res2;
            r_p_left <= i_item.p_c;
            r_x1     <= i_item.pix;
            r_x2     <= r_x1;
        end
    end

    always_comb begin
        case (r_idx)
            2'd0:    w_sel = r_res0;
            2'd1:    w_sel = r_res1;
            default: w_sel = r_res2;
        endcase
    end

    assign o_pop      = w_pop;
    assign o_m_tvalid = r_hold;
    assign o_m_tdata  = w_sel;
    assign o_m_tlast  = w_at_last;

endmodule

FILE: sv/image_gradient_xy_unit.sv
`timescale 1ns / 1ps

// channel   | direction | transaction
// ----------+-----------+------------------------------------------------------
// s_*       | in        | one pixel, raster order
// m_*       | out       | one gradient result, tlast on the last one of a pixel
// apb       | in        | size register write or read
//
// one pixel per cycle; top row pixels give no result, other pixels one, bottom
// row pixels past the first column two and the bottom right one three
// a result passes the stage register, the queue and the result register before it
// is valid; further results of the same pixel follow as each earlier one is taken
// synchronous reset clears control state only, the line stores fill before any read
// either side may stall; the four-entry queue lets the pixel side run on meanwhile

module image_gradient_xy_unit #(
    parameter int MAX_WIDTH  = igxy_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = igxy_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // stream in
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [igxy_pkg::IN_DATA_W-1:0]  i_s_tdata,  // [7:0] pixel
    // stream out
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [9:0] grad_x, [19:10] grad_y, [29:20] out_row, [39:30] out_col
    output logic [igxy_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast,  // last_of_run
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [igxy_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [igxy_pkg::APB_DATA_W-1:0] pwdata,
    output logic [igxy_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // sizes after clamping, minus one
    localparam int LAST_COL_RST =
        ((igxy_pkg::CFG_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : igxy_pkg::CFG_WIDTH_RST) - 1;
    localparam int LAST_ROW_RST =
        ((igxy_pkg::CFG_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : igxy_pkg::CFG_HEIGHT_RST) - 1;

    logic [igxy_pkg::CFG_W-1:0] r_cfg_width;
    logic [igxy_pkg::CFG_W-1:0] r_cfg_height;
    logic [CW-1:0]              r_last_col;
    logic [RW-1:0]              r_last_row;

    logic                       w_cfg_wr;
    igxy_pkg::t_reg_idx         w_reg_idx;
    logic [igxy_pkg::CFG_W-1:0] w_wr_value;
    logic [CW-1:0]              w_col_clamped;
    logic [RW-1:0]              w_row_clamped;

    logic            w_q_full;
    logic            w_push;
    igxy_pkg::t_item w_push_item;
    logic            w_q_valid;
    igxy_pkg::t_item w_q_item;
    logic            w_pop;

    // ------------------------------------------------------------------
    // configuration port: every write also restarts the frame at row 0,
    // column 0; line store contents are kept
    // ------------------------------------------------------------------
    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_reg_idx  = igxy_pkg::t_reg_idx'(paddr[2]);
    assign w_wr_value = pwdata[igxy_pkg::CFG_W-1:0];

    // sizes below two behave as two, sizes above the maximum as the maximum
    always_comb begin
        if (w_wr_value < igxy_pkg::CFG_W'(2)) begin
            w_col_clamped = CW'(1);
            w_row_clamped = RW'(1);
        end else begin
            if (int'(w_wr_value) > MAX_WIDTH) begin
                w_col_clamped = CW'(MAX_WIDTH - 1);
            end else begin
                w_col_clamped = CW'(w_wr_value - igxy_pkg::CFG_W'(1));
            end
            if (int'(w_wr_value) > MAX_HEIGHT) begin
                w_row_clamped = RW'(MAX_HEIGHT - 1);
            end else begin
                w_row_clamped = RW'(w_wr_value - igxy_pkg::CFG_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= igxy_pkg::CFG_W'(igxy_pkg::CFG_WIDTH_RST);
            r_cfg_height <= igxy_pkg::CFG_W'(igxy_pkg::CFG_HEIGHT_RST);
            r_last_col   <= CW'(LAST_COL_RST);
            r_last_row   <= RW'(LAST_ROW_RST);
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                igxy_pkg::REG_WIDTH: begin
                    r_cfg_width <= w_wr_value;
                    r_last_col  <= w_col_clamped;
                end
                igxy_pkg::REG_HEIGHT: begin
                    r_cfg_height <= w_wr_value;
                    r_last_row   <= w_row_clamped;
                end
                default: begin
                    r_cfg_width <= r_cfg_width;
                end
            endcase
        end
    end

    // reads give the value as written, not the clamped one
    always_comb begin
        case (w_reg_idx)
            igxy_pkg::REG_WIDTH:  prdata = igxy_pkg::APB_DATA_W'(r_cfg_width);
            igxy_pkg::REG_HEIGHT: prdata = igxy_pkg::APB_DATA_W'(r_cfg_height);
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // front: position counting, line stores, neighbour fetch
    // ------------------------------------------------------------------
    igxy_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_last_col (r_last_col),
        .i_last_row (r_last_row),
        .i_restart  (w_cfg_wr),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata[igxy_pkg::PIX_W-1:0]),
        .o_s_tready (o_s_tready),
        .i_full     (w_q_full),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    // ------------------------------------------------------------------
    // decoupling queue between pixel side and result side
    // ------------------------------------------------------------------
    igxy_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    // ------------------------------------------------------------------
    // back: gradient arithmetic and result sequencing
    // ------------------------------------------------------------------
    igxy_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_item     (w_q_item),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

FILE: sv/igxy_checker.sv
`timescale 1ns / 1ps

`include "image_gradient_xy_unit_defines.svh"

module igxy_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [igxy_pkg::OUT_DATA_W-1:0] i_out_data,
    input logic                            i_out_last
);

    // a stalled result keeps its payload
    `IGXY_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data) && $stable(i_out_last), "stalled result changed")

    // more results of the same pixel follow without a gap
    `IGXY_ASSERT_NEXT(a_run_continues, i_out_valid && i_out_ready && !i_out_last, i_out_valid, "run of results broken")

    // gradients never leave the doubled pixel range
    `IGXY_ASSERT_NOW(a_grad_range, i_out_valid, ($signed(i_out_data[9:0]) >= -10'sd510) && ($signed(i_out_data[9:0]) <= 10'sd510) && ($signed(i_out_data[19:10]) >= -10'sd510) && ($signed(i_out_data[19:10]) <= 10'sd510), "gradient out of range")

    // reset empties the result side
    `IGXY_ASSERT_ALWAYS(a_reset_clears, !i_rst_n, !i_out_valid, "result valid after reset")

endmodule

bind image_gradient_xy_unit igxy_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_m_tvalid),
    .i_out_ready (i_m_tready),
    .i_out_data  (o_m_tdata),
    .i_out_last  (o_m_tlast)
);
